// File: src/gcs_pkg.sv
// Shared types, codes and constants for the gearshift clutch sequencer.
`timescale 1ns / 1ps

package gcs_pkg;

   // highest usable gear; sensor values above it are invalid
   localparam logic [3:0] TOP_GEAR = 4'd6;

   localparam logic [1:0] FUNC_POLL = 2'd0;
   localparam logic [1:0] FUNC_UP   = 2'd1;
   localparam logic [1:0] FUNC_DOWN = 2'd2;

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_UP   = 2'd1;
   localparam logic [1:0] MODE_DOWN = 2'd2;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_TIMEOUT    = 2'd0;
   localparam logic [1:0] REG_CLUTCH_UP  = 2'd1;
   localparam logic [1:0] REG_CLUTCH_DN  = 2'd2;

   localparam logic [7:0]        TIMEOUT_RESET   = 8'd50;
   localparam logic signed [7:0] CLUTCH_UP_RESET = 8'sd0;
   localparam logic signed [7:0] CLUTCH_DN_RESET = -8'sd75;

   typedef logic signed [6:0] angle_type;

   localparam logic [2:0] TABLE_LAST = 3'd5;

   // downshift row indexed by source gear - 1, upshift row by source gear
   localparam angle_type DOWN_ANGLE [0:5] = '{7'sd36, -7'sd45, -7'sd38, -7'sd38,
                                              -7'sd38, -7'sd38};
   localparam angle_type UP_ANGLE   [0:5] = '{-7'sd47, 7'sd58, 7'sd41, 7'sd49,
                                              7'sd39, 7'sd47};

   typedef struct packed {
      logic [7:0]        timeout_ticks;
      logic signed [7:0] clutch_up_position;
      logic signed [7:0] clutch_down_position;
   } gcs_cfg_type;

   function automatic angle_type table_angle(input logic down, input logic [3:0] idx);
      logic [2:0] col;
      col = (idx > {1'b0, TABLE_LAST}) ? TABLE_LAST : idx[2:0];
      return down ? DOWN_ANGLE[col] : UP_ANGLE[col];
   endfunction

endpackage

// File: src/gcs_req_if.sv
// Request channel interface: valid/ready handshake with the input fields.
`timescale 1ns / 1ps

interface gcs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [3:0] current_gear;
   logic       clutch_ready;

   modport source (output valid, output func, output current_gear,
                   output clutch_ready, input ready);
   modport sink   (input valid, input func, input current_gear,
                   input clutch_ready, output ready);
endinterface

// File: src/gcs_rsp_if.sv
// Response channel interface: valid/ready handshake with the result fields.
`timescale 1ns / 1ps

interface gcs_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] clutch_target;
   logic signed [6:0] shift_target;
   logic              cut_signal;
   logic              blip_signal;
   logic              busy_res;
   logic              finished;
   logic              timed_out;
   logic              request_ignored;

   modport source (output valid, output clutch_target, output shift_target,
                   output cut_signal, output blip_signal, output busy_res,
                   output finished, output timed_out, output request_ignored,
                   input ready);
   modport sink   (input valid, input clutch_target, input shift_target,
                   input cut_signal, input blip_signal, input busy_res,
                   input finished, input timed_out, input request_ignored,
                   output ready);
endinterface

// File: src/gcs_csr.sv
// APB register block holding the timeout and clutch position settings.
`timescale 1ns / 1ps

module gcs_csr
   import gcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output gcs_cfg_type           cfg
);

   gcs_cfg_type cfg_ff, cfg_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TIMEOUT:   cfg_in.timeout_ticks        = pwdata[7:0];
            REG_CLUTCH_UP: cfg_in.clutch_up_position   = pwdata[7:0];
            REG_CLUTCH_DN: cfg_in.clutch_down_position = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks        <= TIMEOUT_RESET;
         cfg_ff.clutch_up_position   <= CLUTCH_UP_RESET;
         cfg_ff.clutch_down_position <= CLUTCH_DN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TIMEOUT:   prdata = {24'd0, cfg_ff.timeout_ticks};
         REG_CLUTCH_UP: prdata = {24'd0, cfg_ff.clutch_up_position};
         REG_CLUTCH_DN: prdata = {24'd0, cfg_ff.clutch_down_position};
         default:       prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: src/gearshift_clutch_sequencer.sv
// Top level: request register, shift sequencing logic and response register.
// Throughput: one request per cycle while the response side is not stalled; the request
// and response registers form a two-stage pipeline, and shift state is updated as a
// request moves into the response.
// Stalls on the response side back up through the request register.
// Reset (synchronous): pipeline empty, shift idle, shift state zero, registers at defaults.
`timescale 1ns / 1ps

module gearshift_clutch_sequencer
   import gcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   gcs_req_if.sink               req_ch,
   gcs_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   gcs_cfg_type cfg;

   gcs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // request stage
   logic       in_valid_ff;
   logic [1:0] in_func_ff;
   logic [3:0] in_gear_ff;
   logic       in_ready_ff;

   // response stage
   logic              out_valid_ff;
   logic signed [7:0] out_clutch_ff;
   logic signed [6:0] out_shift_ff;
   logic              out_cut_ff, out_blip_ff, out_busy_ff;
   logic              out_fin_ff, out_tout_ff, out_ign_ff;

   // shift state
   logic [1:0]        mode_ff, mode_in;
   logic [3:0]        target_ff, target_in;
   angle_type         angle_ff, angle_in;
   angle_type         shift_cmd_ff, shift_cmd_in;
   logic signed [7:0] clutch_cmd_ff, clutch_cmd_in;
   logic [7:0]        ticks_ff, ticks_in;
   logic [3:0]        lvg_ff, lvg_in;

   logic       advance, fire;
   logic       busy, fin, tout, ign, confirmed;
   logic [3:0] src_gear;
   logic [7:0] ticks_inc;

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_func_ff  <= req_ch.func;
         in_gear_ff  <= req_ch.current_gear;
         in_ready_ff <= req_ch.clutch_ready;
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      target_in     = target_ff;
      angle_in      = angle_ff;
      shift_cmd_in  = shift_cmd_ff;
      clutch_cmd_in = clutch_cmd_ff;
      ticks_in      = ticks_ff;
      lvg_in        = lvg_ff;
      fin           = 1'b0;
      tout          = 1'b0;
      ign           = 1'b0;
      confirmed     = 1'b0;
      busy          = mode_ff != MODE_IDLE;
      src_gear      = (in_gear_ff <= TOP_GEAR) ? in_gear_ff : lvg_ff;
      ticks_in      = ticks_ff;
      ticks_inc     = (ticks_ff != 8'hFF) ? ticks_ff + 8'd1 : ticks_ff;

      if (in_gear_ff <= TOP_GEAR) begin
         lvg_in = in_gear_ff;
      end

      case (in_func_ff)
         FUNC_UP: begin
            if (busy || in_gear_ff >= TOP_GEAR) begin
               ign = 1'b1;
            end else begin
               mode_in       = MODE_UP;
               target_in     = in_gear_ff + 4'd1;
               angle_in      = table_angle(1'b0, in_gear_ff);
               clutch_cmd_in = cfg.clutch_up_position;
               shift_cmd_in  = '0;
               ticks_in      = '0;
            end
         end
         FUNC_DOWN: begin
            if (busy || src_gear == 4'd0) begin
               ign = 1'b1;
            end else begin
               mode_in       = MODE_DOWN;
               target_in     = src_gear - 4'd1;
               angle_in      = table_angle(1'b1, src_gear - 4'd1);
               clutch_cmd_in = cfg.clutch_down_position;
               shift_cmd_in  = '0;
               ticks_in      = '0;
            end
         end
         FUNC_POLL: begin
            if (busy) begin
               ticks_in = ticks_inc;
               if (in_ready_ff) begin
                  shift_cmd_in = angle_ff;
               end
               confirmed = in_ready_ff && (in_gear_ff == target_ff);
               if (confirmed || ticks_inc >= cfg.timeout_ticks) begin
                  shift_cmd_in = '0;
                  mode_in      = MODE_IDLE;
                  fin          = 1'b1;
                  tout         = !confirmed;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         target_ff     <= '0;
         angle_ff      <= '0;
         shift_cmd_ff  <= '0;
         clutch_cmd_ff <= '0;
         ticks_ff      <= '0;
         lvg_ff        <= '0;
      end else if (fire) begin
         mode_ff       <= mode_in;
         target_ff     <= target_in;
         angle_ff      <= angle_in;
         shift_cmd_ff  <= shift_cmd_in;
         clutch_cmd_ff <= clutch_cmd_in;
         ticks_ff      <= ticks_in;
         lvg_ff        <= lvg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_clutch_ff <= clutch_cmd_in;
         out_shift_ff  <= shift_cmd_in;
         out_cut_ff    <= mode_in == MODE_UP;
         out_blip_ff   <= mode_in == MODE_DOWN;
         out_busy_ff   <= mode_in != MODE_IDLE;
         out_fin_ff    <= fin;
         out_tout_ff   <= tout;
         out_ign_ff    <= ign;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.clutch_target   = out_clutch_ff;
   assign rsp_ch.shift_target    = out_shift_ff;
   assign rsp_ch.cut_signal      = out_cut_ff;
   assign rsp_ch.blip_signal     = out_blip_ff;
   assign rsp_ch.busy_res        = out_busy_ff;
   assign rsp_ch.finished        = out_fin_ff;
   assign rsp_ch.timed_out       = out_tout_ff;
   assign rsp_ch.request_ignored = out_ign_ff;

   a_tout_needs_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.timed_out |-> rsp_ch.finished && !rsp_ch.busy_res)
      else $error("timeout reported without a finished shift");

   a_cut_blip_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.cut_signal && rsp_ch.blip_signal))
      else $error("cut and blip raised together");

   a_idle_rest: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> shift_cmd_ff == '0)
      else $error("shift motor driven while idle");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(mode_ff) && $stable(ticks_ff))
      else $error("shift state changed without a request moving");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> mode_ff == MODE_IDLE && !out_valid_ff && !in_valid_ff)
      else $error("pipeline or shift not cleared by reset");

endmodule

// File: dv/gearshift_clutch_sequencer_tb.sv
// Testbench for the gearshift clutch sequencer: self-checking scoreboard with random shifts.
`timescale 1ns / 1ps

module gearshift_clutch_sequencer_tb
   import gcs_pkg::*;
();

   // unused function code, behaves like a poll while idle
   localparam logic [1:0] FUNC_NONE = 2'd3;

   typedef struct packed {
      logic signed [7:0] clutch_target;
      logic signed [6:0] shift_target;
      logic              cut_signal;
      logic              blip_signal;
      logic              busy_res;
      logic              finished;
      logic              timed_out;
      logic              request_ignored;
   } shift_outcome_type;

   class shift_scoreboard;
      logic [7:0]        timeout_ticks;
      logic signed [7:0] up_position;
      logic signed [7:0] down_position;
      logic [1:0]        mode;
      logic [3:0]        target_gear;
      angle_type         latched_angle;
      angle_type         shift_cmd;
      logic signed [7:0] clutch_cmd;
      logic [7:0]        elapsed;
      logic [2:0]        last_valid;
      shift_outcome_type shift_outcomes[$];
      int                errors;

      function new();
         timeout_ticks = TIMEOUT_RESET;
         up_position   = CLUTCH_UP_RESET;
         down_position = CLUTCH_DN_RESET;
         mode          = MODE_IDLE;
         target_gear   = '0;
         latched_angle = '0;
         shift_cmd     = '0;
         clutch_cmd    = '0;
         elapsed       = '0;
         last_valid    = '0;
         errors        = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [7:0] value);
         case (idx)
            REG_TIMEOUT:   timeout_ticks = value;
            REG_CLUTCH_UP: up_position = value;
            REG_CLUTCH_DN: down_position = value;
            default: ;
         endcase
      endfunction

      // Advance the shift state by one request and queue the outcome it produces.
      function void record_request(logic [1:0] func, logic [3:0] gear, logic ready);
         shift_outcome_type o;
         logic              busy;
         logic              confirmed;
         logic [3:0]        src;
         int                col;
         o = '0;
         busy = (mode != MODE_IDLE);
         if (gear <= TOP_GEAR) last_valid = gear[2:0];
         case (func)
            FUNC_UP: begin
               if (busy || gear >= TOP_GEAR) begin
                  o.request_ignored = 1'b1;
               end else begin
                  col = (gear > 5) ? 5 : int'(gear);
                  mode = MODE_UP;
                  target_gear = gear + 4'd1;
                  latched_angle = UP_ANGLE[col];
                  clutch_cmd = up_position;
                  shift_cmd = '0;
                  elapsed = '0;
               end
            end
            FUNC_DOWN: begin
               src = (gear <= TOP_GEAR) ? gear : {1'b0, last_valid};
               if (busy || src < 4'd1) begin
                  o.request_ignored = 1'b1;
               end else begin
                  col = (src - 1 > 5) ? 5 : int'(src) - 1;
                  mode = MODE_DOWN;
                  target_gear = src - 4'd1;
                  latched_angle = DOWN_ANGLE[col];
                  clutch_cmd = down_position;
                  shift_cmd = '0;
                  elapsed = '0;
               end
            end
            FUNC_POLL: begin
               if (busy) begin
                  if (elapsed != 8'd255) elapsed = elapsed + 8'd1;
                  if (ready) shift_cmd = latched_angle;
                  confirmed = ready && (gear == target_gear);
                  if (confirmed || elapsed >= timeout_ticks) begin
                     shift_cmd = '0;
                     mode = MODE_IDLE;
                     o.finished = 1'b1;
                     o.timed_out = !confirmed;
                  end
               end
            end
            default: ;
         endcase
         o.clutch_target = clutch_cmd;
         o.shift_target  = shift_cmd;
         o.cut_signal    = (mode == MODE_UP);
         o.blip_signal   = (mode == MODE_DOWN);
         o.busy_res      = (mode != MODE_IDLE);
         shift_outcomes.push_back(o);
      endfunction

      function void compare_field(string name, int want, int seen);
         if (want != seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            errors++;
         end
      endfunction

      function void check_outcome(shift_outcome_type got);
         shift_outcome_type want;
         if (shift_outcomes.size() == 0) begin
            $error("response with no request pending");
            errors++;
         end else begin
            want = shift_outcomes.pop_front();
            compare_field("clutch_target", int'(want.clutch_target),
                          int'(got.clutch_target));
            compare_field("shift_target", int'(want.shift_target), int'(got.shift_target));
            compare_field("cut_signal", int'(want.cut_signal), int'(got.cut_signal));
            compare_field("blip_signal", int'(want.blip_signal), int'(got.blip_signal));
            compare_field("busy_res", int'(want.busy_res), int'(got.busy_res));
            compare_field("finished", int'(want.finished), int'(got.finished));
            compare_field("timed_out", int'(want.timed_out), int'(got.timed_out));
            compare_field("request_ignored", int'(want.request_ignored),
                          int'(got.request_ignored));
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;
   bit                    idle_on = 1'b1;
   shift_scoreboard       sb = new();

   gcs_req_if req_ch();
   gcs_rsp_if rsp_ch();

   gearshift_clutch_sequencer uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Response side: check each accepted response, stall in random bursts.
   initial begin
      shift_outcome_type got;
      int                stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.clutch_target   = rsp_ch.clutch_target;
            got.shift_target    = rsp_ch.shift_target;
            got.cut_signal      = rsp_ch.cut_signal;
            got.blip_signal     = rsp_ch.blip_signal;
            got.busy_res        = rsp_ch.busy_res;
            got.finished        = rsp_ch.finished;
            got.timed_out       = rsp_ch.timed_out;
            got.request_ignored = rsp_ch.request_ignored;
            sb.check_outcome(got);
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(logic [1:0] func, logic [3:0] gear, logic ready);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.func         <= func;
      req_ch.current_gear <= gear;
      req_ch.clutch_ready <= ready;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.record_request(func, gear, ready);
   endtask

   // Drop valid and wait until every outstanding response has been checked.
   task automatic drain_outcomes();
      req_ch.valid <= 1'b0;
      while (sb.shift_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * idx);
      pwdata  <= {24'b0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      // leave the bus idle between transfers
      @(posedge clock);
      sb.set_register(idx, value);
   endtask

   task automatic write_all(logic [7:0] timeout, logic [7:0] up_pos, logic [7:0] down_pos);
      write_csr(REG_TIMEOUT, timeout);
      write_csr(REG_CLUTCH_UP, up_pos);
      write_csr(REG_CLUTCH_DN, down_pos);
   endtask

   // Mostly complete shifts with random polls; the rest is noise.
   task automatic run_random_shifts(int count);
      int         sent;
      logic [1:0] func;
      logic [3:0] gear;
      logic [3:0] goal;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 1) == 1) begin
               func = FUNC_UP;
               gear = 4'($urandom_range(0, 5));
               goal = gear + 4'd1;
            end else begin
               func = FUNC_DOWN;
               gear = 4'($urandom_range(1, 6));
               goal = gear - 4'd1;
               // occasionally let the sensor glitch so the last good gear is used
               if ($urandom_range(0, 5) == 0) gear = 4'($urandom_range(7, 15));
            end
            send_request(func, gear, 1'($urandom_range(0, 1)));
            sent++;
            repeat ($urandom_range(1, 10)) begin
               if ($urandom_range(0, 7) == 0) begin
                  send_request(2'($urandom_range(1, 3)), 4'($urandom_range(0, 15)),
                               1'($urandom_range(0, 1)));
               end else begin
                  send_request(FUNC_POLL,
                               ($urandom_range(0, 2) == 0) ? goal : 4'($urandom_range(0, 15)),
                               $urandom_range(0, 3) != 0);
               end
               sent++;
            end
         end else begin
            send_request(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                         1'($urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.func         <= FUNC_POLL;
      req_ch.current_gear <= '0;
      req_ch.clutch_ready <= 1'b0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults
      send_request(FUNC_POLL, 4'd0, 1'b0);
      send_request(FUNC_NONE, 4'd15, 1'b1);
      send_request(FUNC_UP, 4'd6, 1'b0);
      send_request(FUNC_UP, 4'd15, 1'b1);
      send_request(FUNC_DOWN, 4'd15, 1'b0);
      send_request(FUNC_UP, 4'd2, 1'b0);
      send_request(FUNC_NONE, 4'd5, 1'b1);
      send_request(FUNC_POLL, 4'd5, 1'b0);
      send_request(FUNC_POLL, 4'd4, 1'b1);
      send_request(FUNC_POLL, 4'd5, 1'b1);
      send_request(FUNC_DOWN, 4'd0, 1'b1);
      send_request(FUNC_DOWN, 4'd15, 1'b1);
      send_request(FUNC_UP, 4'd0, 1'b0);
      send_request(FUNC_POLL, 4'd1, 1'b1);
      send_request(FUNC_UP, 4'd5, 1'b0);
      send_request(FUNC_POLL, 4'd6, 1'b1);
      send_request(FUNC_DOWN, 4'd1, 1'b0);
      send_request(FUNC_POLL, 4'd0, 1'b1);
      drain_outcomes();

      write_all(8'd1, 8'h80, 8'h7F);
      send_request(FUNC_UP, 4'd3, 1'b0);
      send_request(FUNC_POLL, 4'd15, 1'b0);
      send_request(FUNC_DOWN, 4'd6, 1'b1);
      send_request(FUNC_POLL, 4'd0, 1'b1);
      run_random_shifts(70);
      drain_outcomes();

      // zero timeout ends a shift on its first poll
      write_all(8'd0, 8'h7F, 8'h80);
      send_request(FUNC_UP, 4'd4, 1'b1);
      send_request(FUNC_POLL, 4'd9, 1'b1);
      run_random_shifts(50);
      drain_outcomes();

      // longest timeout: hold one shift unconfirmed until it expires
      write_csr(REG_TIMEOUT, 8'd255);
      send_request(FUNC_UP, 4'd2, 1'b1);
      repeat (255) send_request(FUNC_POLL, 4'($urandom_range(4, 15)),
                                1'($urandom_range(0, 1)));
      send_request(FUNC_POLL, 4'd3, 1'b1);
      run_random_shifts(50);
      drain_outcomes();

      for (int phase = 0; phase < 4; phase++) begin
         write_all((phase == 1) ? 8'd40 : 8'($urandom_range(1, 12)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         idle_on = (phase != 3);
         run_random_shifts(65);
         drain_outcomes();
      end

      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: gearshift_clutch_sequencer.f
src/gcs_pkg.sv
src/gcs_req_if.sv
src/gcs_rsp_if.sv
src/gcs_csr.sv
src/gearshift_clutch_sequencer.sv
dv/gearshift_clutch_sequencer_tb.sv
